// ===== rtl/core/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg: shared definitions for the multi-stack engine
// Operation and status codes, default sizes, stream packing widths and the
// command and status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package mse_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_STACKS_DEF  = 8;
    localparam int STACK_DEPTH_DEF = 128;

    // Field widths fixed by the interface.
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int ACTIVE_W = 4;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Number of stacks in use after reset.
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    // Operation codes. The unused code is handled like a read of the top.
    localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESULT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // capture the accepted input transfer
        logic exec;        // perform the stack operation
        logic load_out;    // move the result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
    } ctrl_stat_t;

endpackage

// ===== rtl/core/mse_ram.sv =====
// ----------------------------------------------------------------------------
// mse_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mse_ctrl.sv =====
// ----------------------------------------------------------------------------
// mse_ctrl: sequencing state machine of the multi-stack engine
// Accepts one item, lets the datapath run it, then hands the result to the
// output register as soon as that register is free.
// ----------------------------------------------------------------------------
module mse_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mse_pkg::ctrl_stat_t stat,
    output mse_pkg::ctrl_cmd_t  cmd
);
    import mse_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                // No transfer is taken while reset is held.
                s_tready = aresetn;
                if (s_tvalid && s_tready) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/mse_datapath.sv =====
// ----------------------------------------------------------------------------
// mse_datapath: stack storage and operation logic
// Holds the fill counts, the stack RAM, the stacks-in-use register, the
// captured item and the output register.
// ----------------------------------------------------------------------------
module mse_datapath #(
    parameter int MAX_STACKS  = mse_pkg::MAX_STACKS_DEF,
    parameter int STACK_DEPTH = mse_pkg::STACK_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mse_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          cfg_valid,
    input  logic [mse_pkg::ACTIVE_W-1:0]  cfg_data,
    input  mse_pkg::ctrl_cmd_t            cmd,
    output mse_pkg::ctrl_stat_t           stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mse_pkg::M_TDATA_W-1:0] m_tdata
);
    import mse_pkg::*;

    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int IDXW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int RDEP = MAX_STACKS * STACK_DEPTH;
    localparam int AW   = $clog2(RDEP);

    // Captured item.
    logic [ACTION_W-1:0] act_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [VALUE_W-1:0]  val_reg;

    logic [ACTIVE_W-1:0] active_reg;
    logic [CW-1:0]       fill_reg [MAX_STACKS];

    // Result waiting for the output register.
    logic [VALUE_W-1:0]  res_top_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                use_ram_reg;

    logic                m_tvalid_reg;
    logic [VALUE_W-1:0]  m_top_reg;
    logic [STATUS_W-1:0] m_status_reg;

    // Operation decode.
    logic [IDXW-1:0]     fill_idx;
    logic                bad_idx;
    logic [CW-1:0]       cnt;
    logic                empty;
    logic                full;
    logic [AW-1:0]       base;
    logic [AW-1:0]       top_addr;
    logic [STATUS_W-1:0] status_next;
    logic [VALUE_W-1:0]  top_next;
    logic                use_ram_next;
    logic                inc;
    logic                dec;
    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    assign fill_idx = IDXW'(idx_reg);
    assign bad_idx  = ({1'b0, idx_reg} >= active_reg)
                   || (32'(idx_reg) >= 32'(MAX_STACKS));
    assign cnt      = bad_idx ? '0 : fill_reg[fill_idx];
    assign empty    = (cnt == '0);
    assign full     = (cnt == CW'(STACK_DEPTH));
    assign base     = AW'(fill_idx) * AW'(STACK_DEPTH);
    assign top_addr = base + AW'(cnt);    // slot above the top entry

    always_comb begin
        status_next  = ST_OK;
        top_next     = '0;
        use_ram_next = 1'b0;
        inc          = 1'b0;
        dec          = 1'b0;
        ram_raddr    = top_addr - AW'(1);
        if (bad_idx) begin
            status_next = ST_BADIDX;
        end else begin
            case (act_reg)
                ACT_PUSH: begin
                    if (full) begin
                        status_next  = ST_FULL;
                        use_ram_next = 1'b1;
                    end else begin
                        inc      = 1'b1;
                        top_next = val_reg;
                    end
                end
                ACT_POP: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        dec = 1'b1;
                        // The new top sits two below the old fill point.
                        ram_raddr    = top_addr - AW'(2);
                        use_ram_next = (cnt != CW'(1));
                    end
                end
                default: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        use_ram_next = 1'b1;
                    end
                end
            endcase
        end
    end

    assign ram_we = cmd.exec && inc;
    assign ram_re = cmd.exec && use_ram_next;

    mse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (RDEP)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (top_addr),
        .wdata (val_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg <= s_tdata[ACTION_W-1:0];
            idx_reg <= s_tdata[ACTION_W +: INDEX_W];
            val_reg <= s_tdata[ACTION_W+INDEX_W +: VALUE_W];
        end
        if (cmd.exec) begin
            res_top_reg    <= top_next;
            res_status_reg <= status_next;
            use_ram_reg    <= use_ram_next;
        end
        if (cmd.load_out) begin
            m_top_reg    <= use_ram_reg ? ram_rdata : res_top_reg;
            m_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= ACTIVE_RESET;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < MAX_STACKS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                active_reg <= cfg_data;
            end
            if (cmd.exec && inc) begin
                fill_reg[fill_idx] <= cnt + CW'(1);
            end else if (cmd.exec && dec) begin
                fill_reg[fill_idx] <= cnt - CW'(1);
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = {(M_TDATA_W - VALUE_W - STATUS_W)'(0), m_status_reg, m_top_reg};

endmodule

// ===== rtl/core/multi_stack_engine.sv =====
// ----------------------------------------------------------------------------
// multi_stack_engine: several LIFO stacks sharing one RAM
// Each transfer pushes onto, pops from or reads the top of one stack and
// returns the resulting top value with a status code.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  s_*       in         s_tvalid / s_tready   action, stack_index, push_value
//  m_*       out        m_tvalid / m_tready   top_value, status
//  cfg_*     in         cfg_valid / cfg_ready active_stacks
//
//  An item passes through capture, the stack operation with the RAM access
//  and the load of the output register. Each item needs a single RAM
//  access, and the one-item-in-flight controller takes no new item until
//  the previous result is loaded. The output register lets a new item be
//  taken while that result still waits; a stalled result side holds the
//  load step. Synchronous reset empties every stack and sets eight stacks
//  in use. The RAM itself is not cleared, so no startup pass is needed.
//
module multi_stack_engine #(
    parameter int MAX_STACKS  = mse_pkg::MAX_STACKS_DEF,
    parameter int STACK_DEPTH = mse_pkg::STACK_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: action [1:0], stack_index [4:2], push_value [36:5], zero fill
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mse_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: top_value [31:0], status [33:32], zero fill
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mse_pkg::M_TDATA_W-1:0] m_tdata,
    // cfg_data: number of stacks in use
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mse_pkg::ACTIVE_W-1:0]  cfg_data
);
    import mse_pkg::*;

    ctrl_cmd_t  ctrl_cmd;
    ctrl_stat_t ctrl_stat;

    // The register write is taken whenever reset is released; it only
    // changes the stack count.
    assign cfg_ready = aresetn;

    // Controller: accepts an item, runs it and hands off the result.
    mse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (ctrl_stat),
        .cmd      (ctrl_cmd)
    );

    // Datapath: fill counts, stack RAM and output register.
    mse_datapath #(
        .MAX_STACKS  (MAX_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (ctrl_cmd),
        .stat      (ctrl_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // An accepted transfer is executed in the very next cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> ctrl_cmd.exec)
        else $error("accepted item not executed next cycle");

    // No new item is taken while one is being executed.
    a_exec_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.exec |-> !s_tready)
        else $error("input ready during execution");

    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    // A bad stack index always reports a zero top value.
    a_badidx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[33:32] == ST_BADIDX)) |-> (m_tdata[31:0] == '0))
        else $error("bad index with nonzero top value");
`endif

endmodule
